// ===== src/ffpa_pkg.sv =====
// shared constants and types for the first-fit paragraph allocator
`timescale 1ns / 1ps
`default_nettype none
package ffpa_pkg;
    localparam int unsigned MAX_BLOCKS_DEF = 64;
    localparam int unsigned SEG_W = 16;
    localparam logic [SEG_W-1:0] TOTAL_RESET = 16'd40960;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO       = 3'd1,
        ST_EXHAUSTED  = 3'd2,
        ST_NOT_ALLOC  = 3'd3,
        ST_TABLE_FULL = 3'd4
    } status_t;

    typedef struct packed {
        logic [SEG_W-1:0] start;
        logic [SEG_W-1:0] size;
        logic             free;
    } entry_t;
endpackage
`default_nettype wire

// ===== src/ffpa_table.sv =====
// block table memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module ffpa_table #(
    parameter int unsigned DEPTH = ffpa_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  ffpa_pkg::entry_t      wdata,
    input  wire logic [AW-1:0]    raddr,
    output ffpa_pkg::entry_t      rdata
);
    import ffpa_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/first_fit_paragraph_allocator.sv =====
// top level: sequencer walking the block table through one read and one write port
`timescale 1ns / 1ps
`default_nettype none
// First-fit paragraph allocator. One request (allocate or release) is taken
// at a time; in_ready is low until its result beat has been taken. The
// table lives in a single-port-read, single-port-write memory and every step
// reads or writes one entry, so a request walks the table entry by entry:
// a scan of up to block_count entries, then a shift of the entries after the
// split or merge point, then a scan for the largest free block. Any wait on
// out_ready adds to this.
// Writing the total through cfg_we (or reset) empties the table to one free
// block (none if the total is zero) through a live count; no clearing pass is
// needed.
module first_fit_paragraph_allocator #(
    parameter int unsigned MAX_BLOCKS = ffpa_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        mode,
    input  wire logic [15:0] request_size,
    input  wire logic [15:0] release_segment,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [15:0]      granted_segment,
    output logic [15:0]      largest_free
);
    import ffpa_pkg::*;

    localparam int unsigned AW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_RD, S_EVAL, S_SHUP_RD, S_SHUP_WR,
        S_MERGE_RD, S_MERGE_EVAL, S_SHDN_RD, S_SHDN_WR,
        S_MAX_RD, S_MAX_EVAL, S_OUT
    } state_t;

    state_t           state_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    m_reg;
    logic             mode_reg;
    logic [15:0]      want_reg;
    logic [15:0]      seg_reg;
    logic [15:0]      best_reg;
    status_t          st_reg;
    logic [15:0]      grant_reg;
    entry_t           hold_reg;
    entry_t           prev_reg;
    logic             init_reg;
    logic [15:0]      total_reg;

    logic             we;
    logic [AW-1:0]    waddr;
    entry_t           wdata;
    logic [AW-1:0]    raddr;
    entry_t           rdata;

    ffpa_table #(.DEPTH(MAX_BLOCKS), .AW(AW)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign in_ready        = (state_reg == S_IDLE) && !init_reg;
    assign out_valid       = (state_reg == S_OUT);
    assign status          = st_reg;
    assign granted_segment = grant_reg;
    assign largest_free    = best_reg;

    // memory port control
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = hold_reg;
        raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_INIT:
            begin
                we    = (total_reg != 16'd0);
                waddr = '0;
                wdata = '{start: 16'd0, size: total_reg, free: 1'b1};
            end
            S_EVAL:
            begin
                if (mode_reg == 1'b0)
                begin
                    if (rdata.free && rdata.size == want_reg)
                    begin
                        we    = 1'b1;
                        wdata = '{start: rdata.start, size: rdata.size, free: 1'b0};
                    end
                    else if (rdata.free && rdata.size > want_reg && count_reg < CNT_MAX)
                    begin
                        we    = 1'b1;
                        wdata = '{start: rdata.start, size: want_reg, free: 1'b0};
                    end
                end
                else if (rdata.start == seg_reg && !rdata.free)
                begin
                    we    = 1'b1;
                    wdata = '{start: rdata.start, size: rdata.size, free: 1'b1};
                end
            end
            S_SHUP_RD:  raddr = AW'(m_reg - CW'(1));
            S_SHUP_WR:
            begin
                we    = 1'b1;
                waddr = m_reg[AW-1:0];
                wdata = (m_reg == idx_reg + CW'(1)) ? hold_reg : rdata;
            end
            S_MERGE_RD: raddr = idx_reg[AW-1:0];
            S_MERGE_EVAL:
            begin
                if (idx_reg != '0 && prev_reg.free && rdata.free)
                begin
                    we    = 1'b1;
                    waddr = AW'(idx_reg - CW'(1));
                    wdata = '{start: prev_reg.start,
                              size: prev_reg.size + rdata.size, free: 1'b1};
                end
            end
            S_SHDN_RD:  raddr = AW'(m_reg + CW'(1));
            S_SHDN_WR:
            begin
                we    = 1'b1;
                waddr = m_reg[AW-1:0];
                wdata = rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            init_reg  <= 1'b1;
            total_reg <= TOTAL_RESET;
            idx_reg   <= '0;
            m_reg     <= '0;
            best_reg  <= '0;
            st_reg    <= ST_OK;
            grant_reg <= '0;
            mode_reg  <= 1'b0;
            want_reg  <= '0;
            seg_reg   <= '0;
            hold_reg  <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
                init_reg  <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (init_reg && !cfg_we)
                    begin
                        state_reg <= S_INIT;
                    end
                    else if (in_valid && in_ready)
                    begin
                        mode_reg  <= mode;
                        want_reg  <= request_size;
                        seg_reg   <= release_segment;
                        idx_reg   <= '0;
                        grant_reg <= '0;
                        if (mode == 1'b0 && request_size == 16'd0)
                        begin
                            st_reg    <= ST_ZERO;
                            state_reg <= S_MAX_RD;
                        end
                        else if (count_reg == '0)
                        begin
                            st_reg    <= mode ? ST_NOT_ALLOC : ST_EXHAUSTED;
                            state_reg <= S_MAX_RD;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_INIT:
                begin
                    count_reg <= (total_reg != 16'd0) ? CW'(1) : '0;
                    if (!cfg_we)
                    begin
                        init_reg <= 1'b0;
                    end
                    state_reg <= S_IDLE;
                end
                S_RD: state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (mode_reg == 1'b0)
                    begin
                        if (rdata.free && rdata.size == want_reg)
                        begin
                            st_reg    <= ST_OK;
                            grant_reg <= rdata.start;
                            idx_reg   <= '0;
                            state_reg <= S_MAX_RD;
                        end
                        else if (rdata.free && rdata.size > want_reg)
                        begin
                            if (count_reg >= CNT_MAX)
                            begin
                                st_reg    <= ST_TABLE_FULL;
                                idx_reg   <= '0;
                                state_reg <= S_MAX_RD;
                            end
                            else
                            begin
                                st_reg    <= ST_OK;
                                grant_reg <= rdata.start;
                                hold_reg  <= '{start: rdata.start + want_reg,
                                               size: rdata.size - want_reg,
                                               free: 1'b1};
                                m_reg     <= count_reg;
                                state_reg <= S_SHUP_RD;
                            end
                        end
                        else if (idx_reg + CW'(1) >= count_reg)
                        begin
                            st_reg    <= ST_EXHAUSTED;
                            idx_reg   <= '0;
                            state_reg <= S_MAX_RD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        if (rdata.start == seg_reg)
                        begin
                            if (rdata.free)
                            begin
                                st_reg    <= ST_NOT_ALLOC;
                                idx_reg   <= '0;
                                state_reg <= S_MAX_RD;
                            end
                            else
                            begin
                                st_reg    <= ST_OK;
                                idx_reg   <= '0;
                                state_reg <= S_MERGE_RD;
                            end
                        end
                        else if (idx_reg + CW'(1) >= count_reg)
                        begin
                            st_reg    <= ST_NOT_ALLOC;
                            idx_reg   <= '0;
                            state_reg <= S_MAX_RD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                S_SHUP_RD: state_reg <= S_SHUP_WR;
                S_SHUP_WR:
                begin
                    if (m_reg == idx_reg + CW'(1))
                    begin
                        count_reg <= count_reg + CW'(1);
                        idx_reg   <= '0;
                        state_reg <= S_MAX_RD;
                    end
                    else
                    begin
                        m_reg     <= m_reg - CW'(1);
                        state_reg <= S_SHUP_RD;
                    end
                end
                // entry 0 is loaded as prev first, then idx is checked against it each step
                S_MERGE_RD:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_MAX_RD;
                    end
                    else
                    begin
                        state_reg <= S_MERGE_EVAL;
                    end
                end
                S_MERGE_EVAL:
                begin
                    if (idx_reg == '0)
                    begin
                        prev_reg  <= rdata;
                        idx_reg   <= CW'(1);
                        state_reg <= S_MERGE_RD;
                    end
                    else if (prev_reg.free && rdata.free)
                    begin
                        prev_reg.size <= prev_reg.size + rdata.size;
                        m_reg         <= idx_reg;
                        if (idx_reg + CW'(1) >= count_reg)
                        begin
                            count_reg <= count_reg - CW'(1);
                            state_reg <= S_MERGE_RD;
                        end
                        else
                        begin
                            state_reg <= S_SHDN_RD;
                        end
                    end
                    else
                    begin
                        prev_reg  <= rdata;
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_MERGE_RD;
                    end
                end
                S_SHDN_RD: state_reg <= S_SHDN_WR;
                S_SHDN_WR:
                begin
                    if (m_reg + CW'(2) >= count_reg)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_MERGE_RD;
                    end
                    else
                    begin
                        m_reg     <= m_reg + CW'(1);
                        state_reg <= S_SHDN_RD;
                    end
                end
                S_MAX_RD:
                begin
                    if (idx_reg == '0)
                    begin
                        best_reg <= '0;
                    end
                    if (idx_reg >= count_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_MAX_EVAL;
                    end
                end
                S_MAX_EVAL:
                begin
                    if (rdata.free && (idx_reg == '0 || rdata.size > best_reg))
                    begin
                        best_reg <= rdata.size;
                    end
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= S_MAX_RD;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the first-fit paragraph allocator
`timescale 1ns / 1ps
module testbench;
    import ffpa_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    typedef enum logic {MODE_ALLOC = 1'b0, MODE_RELEASE = 1'b1} mode_t;

    typedef struct {
        mode_t       op;
        logic [15:0] want;
        logic [15:0] seg;
    } request_t;

    typedef struct {
        status_t     st;
        logic [15:0] grant;
        logic [15:0] widest;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic mode = 1'b0;
    logic [15:0] request_size = 16'd0;
    logic [15:0] release_segment = 16'd0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic [15:0] granted_segment;
    logic [15:0] largest_free;

    first_fit_paragraph_allocator DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .request_size(request_size), .release_segment(release_segment),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .granted_segment(granted_segment), .largest_free(largest_free)
    );

    always #1 clk = ~clk;

    // allocator state mirror
    logic [15:0] blk_start [TABLE_DEPTH];
    logic [15:0] blk_size [TABLE_DEPTH];
    logic        blk_free [TABLE_DEPTH];
    int          blk_count;
    logic [15:0] total_size;

    request_t pending_requests [$];
    answer_t  expected_answers [$];
    int error_count = 0;
    int beats_in = 0;
    int beats_out = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_phase = 0;
    bit stim_done = 1'b0;
    int alloc_count = 0;
    int release_count = 0;
    int config_count = 0;

    function automatic void queue_request(request_t r);
        pending_requests.insert(pending_requests.size(), r);
        if (r.op == MODE_ALLOC)
            alloc_count++;
        else
            release_count++;
    endfunction

    function automatic void load_total(logic [15:0] total);
        total_size = total;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            blk_start[k] = '0;
            blk_size[k] = '0;
            blk_free[k] = 1'b0;
        end
        if (total != 0)
        begin
            blk_size[0] = total;
            blk_free[0] = 1'b1;
            blk_count = 1;
        end
        else
            blk_count = 0;
    endfunction

    function automatic logic [15:0] widest_free_block();
        logic [15:0] best;
        best = '0;
        for (int k = 0; k < blk_count; k++)
            if (blk_free[k] && blk_size[k] > best)
                best = blk_size[k];
        return best;
    endfunction

    function automatic status_t grant_block(logic [15:0] want, output logic [15:0] where);
        where = '0;
        if (want == 0)
            return ST_ZERO;
        for (int k = 0; k < blk_count; k++)
        begin
            if (!blk_free[k] || blk_size[k] < want)
                continue;
            if (blk_size[k] == want)
            begin
                blk_free[k] = 1'b0;
                where = blk_start[k];
                return ST_OK;
            end
            if (blk_count >= TABLE_DEPTH)
                return ST_TABLE_FULL;
            for (int m = blk_count; m > k + 1; m--)
            begin
                blk_start[m] = blk_start[m-1];
                blk_size[m] = blk_size[m-1];
                blk_free[m] = blk_free[m-1];
            end
            blk_start[k+1] = blk_start[k] + want;
            blk_size[k+1] = blk_size[k] - want;
            blk_free[k+1] = 1'b1;
            blk_size[k] = want;
            blk_free[k] = 1'b0;
            blk_count++;
            where = blk_start[k];
            return ST_OK;
        end
        return ST_EXHAUSTED;
    endfunction

    function automatic status_t release_block(logic [15:0] seg);
        int k;
        k = 0;
        while (k < blk_count && blk_start[k] != seg)
            k++;
        if (k >= blk_count || blk_free[k])
            return ST_NOT_ALLOC;
        blk_free[k] = 1'b1;
        k = 0;
        while (k + 1 < blk_count)
        begin
            if (blk_free[k] && blk_free[k+1])
            begin
                blk_size[k] = blk_size[k] + blk_size[k+1];
                for (int m = k + 1; m + 1 < blk_count; m++)
                begin
                    blk_start[m] = blk_start[m+1];
                    blk_size[m] = blk_size[m+1];
                    blk_free[m] = blk_free[m+1];
                end
                blk_count--;
            end
            else
                k++;
        end
        return ST_OK;
    endfunction

    function automatic answer_t apply_request(request_t req);
        answer_t ans;
        logic [15:0] where;
        where = '0;
        if (req.op == MODE_ALLOC)
            ans.st = grant_block(req.want, where);
        else
            ans.st = release_block(req.seg);
        ans.grant = (ans.st == ST_OK) ? where : 16'd0;
        ans.widest = widest_free_block();
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch on beat %0d: %s got %0d expected %0d", beats_out, what, got, want);
        error_count++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            expected_answers.insert(expected_answers.size(),
                                    apply_request(pending_requests.pop_front()));
            beats_in++;
        end
        if (!(in_valid && !in_ready))
        begin
            if (burst_left == 0 && gap_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                burst_left--;
                in_valid <= 1'b1;
                mode <= pending_requests[0].op;
                request_size <= pending_requests[0].want;
                release_segment <= pending_requests[0].seg;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and output stall pattern
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            beats_out++;
            if (expected_answers.size() == 0)
            begin
                $display("unexpected result beat %0d", beats_out);
                error_count++;
            end
            else
            begin
                answer_t exp_ans;
                exp_ans = expected_answers.pop_front();
                if (status !== exp_ans.st)
                    report_mismatch("status", 16'(status), 16'(exp_ans.st));
                if (granted_segment !== exp_ans.grant)
                    report_mismatch("granted_segment", granted_segment, exp_ans.grant);
                if (largest_free !== exp_ans.widest)
                    report_mismatch("largest_free", largest_free, exp_ans.widest);
            end
        end
        stall_phase = (stall_phase + 1) % 400;
        if (stall_phase < 100)
            out_ready <= 1'b1;
        else if (stall_phase < 250)
            out_ready <= ($urandom_range(0, 2) != 0);
        else
            out_ready <= ($urandom_range(0, 4) == 0);
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else if (!stim_done || expected_answers.size() > 0)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout with %0d results outstanding", expected_answers.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic request_t alloc_req(logic [15:0] want);
        request_t r;
        r.op = MODE_ALLOC;
        r.want = want;
        r.seg = 16'($urandom());
        return r;
    endfunction

    function automatic request_t release_req(logic [15:0] seg);
        request_t r;
        r.op = MODE_RELEASE;
        r.want = 16'($urandom());
        r.seg = seg;
        return r;
    endfunction

    task automatic drain();
        wait (pending_requests.size() == 0 && !in_valid);
        wait (expected_answers.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic drain_quick();
        wait (pending_requests.size() == 0);
        wait (expected_answers.size() == 0);
    endtask

    task automatic write_total(logic [15:0] total);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= total;
        @(posedge clk);
        cfg_we <= 1'b0;
        load_total(total);
        config_count++;
    endtask

    // random traffic, mostly small allocations and releases of real starts, some malformed
    task automatic random_phase(int count, int max_want);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                request_t r;
                r = alloc_req(16'($urandom_range(1, max_want)));
                if ($urandom_range(0, 19) == 0)
                    r.want = 16'($urandom());
                queue_request(r);
            end
            else if (pick < 92)
            begin
                // release a likely start: sums of sizes are unknown ahead, so guess from table
                logic [15:0] seg;
                seg = (blk_count > 0) ? blk_start[$urandom_range(0, blk_count - 1)] : 16'd0;
                if ($urandom_range(0, 3) == 0)
                    seg = 16'($urandom_range(0, max_want * 8));
                queue_request(release_req(seg));
            end
            else
            begin
                request_t r;
                r = alloc_req(16'($urandom()));
                r.op = mode_t'($urandom_range(0, 1));
                r.seg = 16'($urandom());
                queue_request(r);
            end
            // keep the mirror close so release guesses hit real blocks
            if (n % 4 == 3)
                drain_quick();
        end
    endtask

    initial
    begin
        load_total(TOTAL_RESET);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero size, no fit, bad releases, double release
        queue_request(alloc_req(16'd0));
        queue_request(alloc_req(16'hFFFF));
        queue_request(alloc_req(16'd1));
        queue_request(alloc_req(16'd40958));
        queue_request(alloc_req(16'd1));
        queue_request(alloc_req(16'd1));
        queue_request(release_req(16'd1));
        queue_request(release_req(16'd1));
        queue_request(release_req(16'hFFFF));
        queue_request(release_req(16'd0));
        queue_request(release_req(16'd40959));
        queue_request(alloc_req(16'd40960));
        queue_request(release_req(16'd0));
        drain();

        write_total(16'hFFFF);
        queue_request(alloc_req(16'hFFFF));
        queue_request(alloc_req(16'd1));
        queue_request(release_req(16'd0));
        drain();

        // fill the table so later splits hit the full-table case
        write_total(16'd200);
        for (int k = 0; k < TABLE_DEPTH; k++)
            queue_request(alloc_req(16'd2));
        queue_request(release_req(16'd4));
        queue_request(alloc_req(16'd1));
        queue_request(alloc_req(16'd2));
        drain();

        write_total(16'd0);
        queue_request(alloc_req(16'd1));
        queue_request(release_req(16'd0));
        drain();

        write_total(16'd1);
        random_phase(40, 1);
        drain();
        write_total(16'd40960);
        random_phase(330, 400);
        drain();
        write_total(16'd150);
        random_phase(260, 4);
        drain();
        write_total(16'($urandom_range(100, 65535)));
        random_phase(120, 4000);
        drain();

        stim_done = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d allocates and %0d releases over %0d table sizes",
                 alloc_count, release_count, config_count + 1);
        $display("%0d request beats and %0d result beats checked", beats_in, beats_out);
        if (error_count == 0 && expected_answers.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
